/* hdl/psrh_pkg.sv */
// Shared types and constants for the stepper rate controller with homing.
package psrh_pkg;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_RATE_LIMIT  = 3'd3,
        REG_HOME_WINDOW = 3'd4,
        REG_HOMING_RATE = 3'd5,
        REG_DEAD_BAND   = 3'd6
    } cfg_idx_t;

    // Register reset values.
    localparam logic [15:0] GAIN_P_RST      = 16'd256;
    localparam logic [15:0] GAIN_I_RST      = 16'd0;
    localparam logic [15:0] GAIN_D_RST      = 16'd0;
    localparam logic [15:0] RATE_LIMIT_RST  = 16'd5000;
    localparam logic [11:0] HOME_WINDOW_RST = 12'd56;
    localparam logic [15:0] HOMING_RATE_RST = 16'd5000;
    localparam logic [7:0]  DEAD_BAND_RST   = 8'd1;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // Datapath widths.
    localparam int ERR_W  = 17;     // position error
    localparam int DIFF_W = 18;     // error difference
    localparam int SUM_W  = 15;     // integral accumulator
    localparam int ACC_W  = 36;     // weighted sum of the three terms
    localparam int DRV_W  = 17;     // clamped drive

    // Angle to count scale: 4096 counts per 2*pi radians, so a Q4.12 angle
    // times 163/1024 gives encoder counts.
    localparam logic signed [24:0] ANGLE_MUL  = 25'sd163;
    localparam logic signed [24:0] ANGLE_RND  = 25'sd1023;
    localparam logic signed [17:0] SUM_LIMIT  = 18'sd10000;
    localparam logic signed [ACC_W-1:0] DIV_RND = 36'sd255;

    // Per-item control flags that follow the data down the pipeline.
    typedef struct packed {
        logic run;      // the controller ran for this item
        logic homing;   // the result is a homing command
    } item_flags_t;

endpackage

/* hdl/pid_stepper_rate_with_homing_unit.sv */
// Top level: single-axis stepper rate controller with homing and a clamped PID.
//
// Usage. Each input beat on the s_ side carries one control tick: a target
// angle (signed Q4.12 radians) and the measured encoder position in counts.
// Every tick gives exactly one result beat on the m_ side: the step direction,
// the step rate magnitude and, in m_tuser, a flag that marks a homing command.
// Gains and limits are written through the cfg_ port, one register per beat;
// cfg_ready is always high, and writes are meant to happen while the block
// holds no tick in flight. Indexes beyond the register list are ignored.
//
// Timing. The datapath is a six-stage pipeline: input register, angle scaling
// and homing decision, error/integral update, the three gain multipliers,
// the sum of the products, and the divide, clamp and output register. One beat
// per cycle is sustained while the receiver keeps m_tready high. Each stage
// has its own valid bit and loads whenever it is empty or its content moves on,
// so empty stages keep taking beats while a finished result waits on m_tready;
// s_tready only drops once every stage is full and the receiver stalls.
//
// Reset. rst_n clears all valid bits, the homing state and the controller
// state, and loads the register defaults. The first ticks after reset drive
// toward home until the position is inside the home window.
module pid_stepper_rate_with_homing_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [psrh_pkg::IN_DATA_W-1:0]         s_tdata,   // [15:0] target_angle,
                                                              // [31:16] measured_pos
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [psrh_pkg::OUT_DATA_W-1:0]        m_tdata,   // [0] step_dir,
                                                              // [16:1] step_rate, rest zero
    output logic                                   m_tuser,   // [0] homing
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [psrh_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [psrh_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import psrh_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] gain_p_reg;
    logic [15:0] gain_i_reg;
    logic [15:0] gain_d_reg;
    logic [15:0] rate_limit_reg;
    logic [11:0] home_window_reg;
    logic [15:0] homing_rate_reg;
    logic [7:0]  dead_band_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= GAIN_P_RST;
            gain_i_reg      <= GAIN_I_RST;
            gain_d_reg      <= GAIN_D_RST;
            rate_limit_reg  <= RATE_LIMIT_RST;
            home_window_reg <= HOME_WINDOW_RST;
            homing_rate_reg <= HOMING_RATE_RST;
            dead_band_reg   <= DEAD_BAND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_GAIN_P:      gain_p_reg      <= cfg_data;
                REG_GAIN_I:      gain_i_reg      <= cfg_data;
                REG_GAIN_D:      gain_d_reg      <= cfg_data;
                REG_RATE_LIMIT:  rate_limit_reg  <= cfg_data;
                REG_HOME_WINDOW: home_window_reg <= cfg_data[11:0];
                REG_HOMING_RATE: homing_rate_reg <= cfg_data;
                REG_DEAD_BAND:   dead_band_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when empty or when it drains.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic load1, load2, load3, load4, load5, load6;

    assign load6 = !out_valid_reg || m_tready;
    assign load5 = !s5_valid_reg  || load6;
    assign load4 = !s4_valid_reg  || load5;
    assign load3 = !s3_valid_reg  || load4;
    assign load2 = !s2_valid_reg  || load3;
    assign load1 = !s1_valid_reg  || load2;

    assign s_tready = load1;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1) s1_valid_reg  <= s_tvalid;
            if (load2) s2_valid_reg  <= s1_valid_reg;
            if (load3) s3_valid_reg  <= s2_valid_reg;
            if (load4) s4_valid_reg  <= s3_valid_reg;
            if (load5) s5_valid_reg  <= s4_valid_reg;
            if (load6) out_valid_reg <= s5_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    logic signed [15:0] s1_angle_reg;
    logic signed [15:0] s1_pos_reg;

    always_ff @(posedge clk)
    begin
        if (load1 && s_tvalid)
        begin
            s1_angle_reg <= s_tdata[15:0];
            s1_pos_reg   <= s_tdata[31:16];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: angle to counts, position error and the homing decision.
    // The homing flag is the only state updated here.
    // ------------------------------------------------------------------
    logic                    home_done_reg;
    logic                    home_done_next;
    logic signed [24:0]      angle_prod;
    logic signed [24:0]      angle_adj;
    logic signed [ERR_W-1:0] err_next;
    logic [16:0]             pos_mag;
    item_flags_t             s2_flags_next;
    logic signed [ERR_W-1:0] s2_err_reg;
    item_flags_t             s2_flags_reg;

    always_comb
    begin
        // Scale by 163/1024, truncating toward zero.
        angle_prod = $signed({{9{s1_angle_reg[15]}}, s1_angle_reg}) * ANGLE_MUL;
        angle_adj  = angle_prod + (angle_prod[24] ? ANGLE_RND : 25'sd0);
        err_next   = $signed({{2{angle_adj[24]}}, angle_adj[24:10]})
                   - $signed({s1_pos_reg[15], s1_pos_reg});

        pos_mag = s1_pos_reg[15] ? 17'(-$signed({s1_pos_reg[15], s1_pos_reg}))
                                 : {1'b0, s1_pos_reg};

        // The controller runs from the tick after homing completes.
        s2_flags_next.run    = home_done_reg;
        s2_flags_next.homing = !home_done_reg && (pos_mag > {5'd0, home_window_reg});
        home_done_next       = home_done_reg || !s2_flags_next.homing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_done_reg <= 1'b0;
        end
        else if (load2 && s1_valid_reg)
        begin
            home_done_reg <= home_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2 && s1_valid_reg)
        begin
            s2_err_reg   <= err_next;
            s2_flags_reg <= s2_flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: derivative, dead band and clamped integral.
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic [ERR_W-1:0]         err_mag;
    logic signed [ERR_W-1:0]  err_db;
    logic signed [17:0]       sum_raw;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [ERR_W-1:0]  s3_err_reg;
    logic signed [DIFF_W-1:0] s3_diff_reg;
    logic signed [SUM_W-1:0]  s3_sum_reg;
    item_flags_t              s3_flags_reg;

    always_comb
    begin
        diff_next = $signed({s2_err_reg[ERR_W-1], s2_err_reg})
                  - $signed({last_error_reg[ERR_W-1], last_error_reg});
        err_mag   = s2_err_reg[ERR_W-1] ? ERR_W'(-s2_err_reg) : s2_err_reg;
        err_db    = (err_mag < {9'd0, dead_band_reg}) ? '0 : s2_err_reg;
        sum_raw   = $signed({{3{error_sum_reg[SUM_W-1]}}, error_sum_reg})
                  + $signed({err_db[ERR_W-1], err_db});
        if (sum_raw > SUM_LIMIT)
            sum_next = SUM_W'(SUM_LIMIT);
        else if (sum_raw < -SUM_LIMIT)
            sum_next = SUM_W'(-SUM_LIMIT);
        else
            sum_next = sum_raw[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else if (load3 && s2_valid_reg && s2_flags_reg.run)
        begin
            last_error_reg <= s2_err_reg;
            error_sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3 && s2_valid_reg)
        begin
            s3_err_reg   <= err_db;
            s3_diff_reg  <= diff_next;
            s3_sum_reg   <= sum_next;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: the three gain products.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] s4_prod_p_reg;
    logic signed [ACC_W-1:0] s4_prod_i_reg;
    logic signed [ACC_W-1:0] s4_prod_d_reg;
    item_flags_t             s4_flags_reg;

    always_ff @(posedge clk)
    begin
        if (load4 && s3_valid_reg)
        begin
            s4_prod_p_reg <= $signed({20'd0, gain_p_reg})
                           * $signed({{19{s3_err_reg[ERR_W-1]}}, s3_err_reg});
            s4_prod_i_reg <= $signed({20'd0, gain_i_reg})
                           * $signed({{21{s3_sum_reg[SUM_W-1]}}, s3_sum_reg});
            s4_prod_d_reg <= $signed({20'd0, gain_d_reg})
                           * $signed({{18{s3_diff_reg[DIFF_W-1]}}, s3_diff_reg});
            s4_flags_reg  <= s3_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: weighted sum; the derivative term is subtracted.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] s5_acc_reg;
    item_flags_t             s5_flags_reg;

    always_ff @(posedge clk)
    begin
        if (load5 && s4_valid_reg)
        begin
            s5_acc_reg   <= s4_prod_p_reg - s4_prod_d_reg + s4_prod_i_reg;
            s5_flags_reg <= s4_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: divide by 256 toward zero, clamp, sign and magnitude.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_adj;
    logic signed [27:0]      quot;
    logic signed [27:0]      lim_wide;
    logic signed [DRV_W-1:0] drive;
    logic                    dir_next;
    logic [15:0]             rate_next;
    logic                    out_dir_reg;
    logic [15:0]             out_rate_reg;
    logic                    out_homing_reg;

    always_comb
    begin
        acc_adj  = s5_acc_reg + (s5_acc_reg[ACC_W-1] ? DIV_RND : '0);
        quot     = acc_adj[ACC_W-1:8];
        lim_wide = $signed({12'd0, rate_limit_reg});
        if (quot > lim_wide)
            drive = $signed({1'b0, rate_limit_reg});
        else if (quot < -lim_wide)
            drive = DRV_W'(-lim_wide);
        else
            drive = quot[DRV_W-1:0];

        if (s5_flags_reg.homing)
        begin
            dir_next  = 1'b1;
            rate_next = homing_rate_reg;
        end
        else if (!s5_flags_reg.run)
        begin
            // Homing just finished: the drive is still at its reset value.
            dir_next  = 1'b1;
            rate_next = '0;
        end
        else
        begin
            dir_next  = !(drive > 0);
            rate_next = drive[DRV_W-1] ? 16'(-drive) : drive[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load6 && s5_valid_reg)
        begin
            out_dir_reg    <= dir_next;
            out_rate_reg   <= rate_next;
            out_homing_reg <= s5_flags_reg.homing;
        end
    end

    assign m_tdata = {7'd0, out_rate_reg, out_dir_reg};
    assign m_tuser = out_homing_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Homing completes once and never restarts without a reset.
    a_home_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        home_done_reg |=> home_done_reg)
        else $error("homing state cleared after completion");

    // An item marked to run the controller was admitted after homing finished.
    a_run_after_home: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_flags_reg.run) |-> home_done_reg)
        else $error("controller item in flight before homing completed");

    // The integral stays inside its clamp.
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (error_sum_reg <= SUM_W'(SUM_LIMIT)) && (error_sum_reg >= SUM_W'(-SUM_LIMIT)))
        else $error("integral outside its limit");

endmodule

/* sim/pid_stepper_rate_with_homing_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the stepper rate controller with homing and a clamped PID.
module pid_stepper_rate_with_homing_unit_tb;
    import psrh_pkg::*;

    // Index past the end of the register list; writes to it must be dropped.
    localparam logic [2:0] REG_SPARE = 3'd7;
    // Angle scaling is (angle * 163) / 1024, truncated toward zero.
    localparam int COUNTS_DIV = 1024;
    localparam int PHASES = 8;
    localparam int TICKS_PER_PHASE = 190;
    // The pipeline is six stages deep, so a quiet wait of SETTLE_CYCLES leaves it empty.
    localparam int SETTLE_CYCLES = 12;
    // Length of each deliberate receiver stall that backs up the pipeline.
    localparam int BACKLOG_CYCLES = 250;

    // One step command as it leaves the block.
    typedef struct packed {
        logic        dir;
        logic [15:0] rate;
        logic        homing;
    } step_cmd_t;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

    // A directed row is either a control tick (a = angle, b = position) or a
    // register write (a = index, b = value). Rows marked typed carry their
    // expected command; the others are checked against the predictor.
    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] a;
        logic [15:0] b;
        logic        typed;
        step_cmd_t   want;
    } plan_row_t;

    localparam int PLAN_LEN = 32;

    plan_row_t plan [PLAN_LEN] = '{
        // Homing with the default window and rate, including the field extremes.
        '{ROW_TICK, 16'd0,      16'd1000,   1'b1, '{1'b1, 16'd5000, 1'b1}},
        '{ROW_TICK, 16'h7FFF,   16'h8000,   1'b1, '{1'b1, 16'd5000, 1'b1}},
        '{ROW_TICK, 16'h8000,   16'h7FFF,   1'b1, '{1'b1, 16'd5000, 1'b1}},
        '{ROW_TICK, 16'd0,      16'd57,     1'b1, '{1'b1, 16'd5000, 1'b1}},
        // Fastest homing rate and a closed window; the spare index is ignored.
        '{ROW_REG,  16'(REG_HOMING_RATE), 16'hFFFF, 1'b0, '0},
        '{ROW_REG,  16'(REG_HOME_WINDOW), 16'h0000, 1'b0, '0},
        '{ROW_REG,  16'(REG_SPARE),       16'h0003, 1'b0, '0},
        '{ROW_TICK, 16'd0,      16'd1,      1'b1, '{1'b1, 16'hFFFF, 1'b1}},
        '{ROW_TICK, 16'd0,      16'hFFFF,   1'b1, '{1'b1, 16'hFFFF, 1'b1}},
        // Homing finishes here: the output still comes from the reset drive.
        '{ROW_TICK, 16'd1234,   16'd0,      1'b1, '{1'b1, 16'd0,    1'b0}},
        // First PID ticks with the default gains.
        '{ROW_TICK, 16'd0,      16'd0,      1'b1, '{1'b1, 16'd0,    1'b0}},
        '{ROW_TICK, 16'd0,      16'(-100),  1'b1, '{1'b0, 16'd100,  1'b0}},
        '{ROW_TICK, 16'h7FFF,   16'h8000,   1'b1, '{1'b0, 16'd5000, 1'b0}},
        '{ROW_TICK, 16'h8000,   16'h7FFF,   1'b1, '{1'b1, 16'd5000, 1'b0}},
        '{ROW_TICK, 16'd0,      16'hFFFF,   1'b0, '0},
        // Widest deadband: an error of 254 vanishes, 255 does not.
        '{ROW_REG,  16'(REG_DEAD_BAND),   16'h00FF, 1'b0, '0},
        '{ROW_TICK, 16'd0,      16'(-254),  1'b1, '{1'b1, 16'd0,    1'b0}},
        '{ROW_TICK, 16'd0,      16'(-255),  1'b0, '0},
        // No deadband at all.
        '{ROW_REG,  16'(REG_DEAD_BAND),   16'h0000, 1'b0, '0},
        '{ROW_TICK, 16'd0,      16'd0,      1'b0, '0},
        // Every gain and the rate limit at full scale; the integral saturates.
        '{ROW_REG,  16'(REG_GAIN_P),      16'hFFFF, 1'b0, '0},
        '{ROW_REG,  16'(REG_GAIN_I),      16'hFFFF, 1'b0, '0},
        '{ROW_REG,  16'(REG_GAIN_D),      16'hFFFF, 1'b0, '0},
        '{ROW_REG,  16'(REG_RATE_LIMIT),  16'hFFFF, 1'b0, '0},
        '{ROW_TICK, 16'h7FFF,   16'h8000,   1'b0, '0},
        '{ROW_TICK, 16'h8000,   16'h7FFF,   1'b0, '0},
        '{ROW_TICK, 16'd0,      16'd0,      1'b0, '0},
        '{ROW_TICK, 16'd0,      16'd3,      1'b0, '0},
        // A zero rate limit pins the drive at zero.
        '{ROW_REG,  16'(REG_RATE_LIMIT),  16'h0000, 1'b0, '0},
        '{ROW_TICK, 16'd5000,   16'd7,      1'b1, '{1'b1, 16'd0,    1'b0}},
        // Homing registers at their other extremes; they no longer matter.
        '{ROW_REG,  16'(REG_HOME_WINDOW), 16'h0FFF, 1'b0, '0},
        '{ROW_REG,  16'(REG_HOMING_RATE), 16'h0000, 1'b0, '0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the register file, updated when a write beat is accepted.
    logic [15:0] kp = GAIN_P_RST;
    logic [15:0] ki = GAIN_I_RST;
    logic [15:0] kd = GAIN_D_RST;
    logic [15:0] rate_lim = RATE_LIMIT_RST;
    logic [11:0] home_win = HOME_WINDOW_RST;
    logic [15:0] home_rate = HOMING_RATE_RST;
    logic [7:0]  dband = DEAD_BAND_RST;

    // Controller state as the predictor sees it.
    logic               homed = 1'b0;
    logic               pid_on = 1'b0;
    logic signed [17:0] prev_err = '0;
    logic signed [14:0] err_sum = '0;
    logic signed [16:0] drive_now = '0;

    // Commands owed by the block, oldest first.
    step_cmd_t step_cmds_due [$];
    int unsigned cmds_seen = 0;
    int unsigned mismatch_count = 0;

    pid_stepper_rate_with_homing_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] target_angle, [31:16] measured_pos
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [0] step_dir, [16:1] step_rate, rest zero
        .m_tuser   (m_tuser),    // [0] homing
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Target in encoder counts, truncated toward zero like the block does.
    function automatic int angle_to_counts(logic signed [15:0] ang);
        return (int'(ang) * int'(ANGLE_MUL)) / COUNTS_DIV;
    endfunction

    // Advances the controller by one tick and returns the command it emits.
    // The PID update happens before the homing check, so the tick on which
    // homing finishes still reports the old drive.
    function automatic step_cmd_t predict_step_cmd(logic signed [15:0] ang,
                                                   logic signed [15:0] pos);
        int     p;
        int     err;
        int     diff;
        int     acc_sum;
        longint mix;
        p = pos;
        if (pid_on)
        begin
            err = angle_to_counts(ang) - p;
            // The derivative uses the raw error, before the deadband.
            diff = err - int'(prev_err);
            prev_err = 18'(err);
            if ((err < 0 ? -err : err) < int'(dband))
                err = 0;
            acc_sum = int'(err_sum) + err;
            if (acc_sum > int'(SUM_LIMIT))
                acc_sum = int'(SUM_LIMIT);
            if (acc_sum < -int'(SUM_LIMIT))
                acc_sum = -int'(SUM_LIMIT);
            err_sum = 15'(acc_sum);
            // The full-width sum is divided once, truncating toward zero.
            mix = longint'(kp) * err - longint'(kd) * diff + longint'(ki) * acc_sum;
            mix = mix / 256;
            if (mix > longint'(rate_lim))
                mix = longint'(rate_lim);
            if (mix < -longint'(rate_lim))
                mix = -longint'(rate_lim);
            drive_now = 17'(mix);
        end
        if (!homed && (p < 0 ? -p : p) > int'(home_win))
            return '{1'b1, home_rate, 1'b1};
        homed = 1'b1;
        pid_on = 1'b1;
        if (drive_now > 0)
            return '{1'b0, drive_now[15:0], 1'b0};
        return '{1'b1, 16'(-int'(drive_now)), 1'b0};
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 40));
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("beat %0d: %s is %0h, expected %0h", cmds_seen, what, got, want);
        mismatch_count++;
    endtask

    // Offers one tick and waits for its beat. The expected command is queued
    // at the accepting edge; a typed row replaces the predicted one, but the
    // predictor still steps so its state stays in line with the block.
    task automatic send_tick(logic [15:0] ang, logic [15:0] pos, logic typed,
                             step_cmd_t want);
        step_cmd_t cmd;
        s_tdata <= {pos, ang};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cmd = predict_step_cmd(ang, pos);
        step_cmds_due.push_back(typed ? want : cmd);
    endtask

    // Drops tvalid for a while; a zero gap leaves it high for the next tick.
    task automatic idle_src(int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering ticks and waits until every owed command has arrived and
    // the pipeline has had time to empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (step_cmds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_addr <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GAIN_P:      kp = val;
            REG_GAIN_I:      ki = val;
            REG_GAIN_D:      kd = val;
            REG_RATE_LIMIT:  rate_lim = val;
            REG_HOME_WINDOW: home_win = val[11:0];
            REG_HOMING_RATE: home_rate = val;
            REG_DEAD_BAND:   dband = val[7:0];
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker. Values read at the edge are the ones the block saw,
    // since every input is driven with nonblocking assignments.
    always @(posedge clk)
    begin
        step_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            cmds_seen++;
            if (step_cmds_due.size() == 0)
                flag_mismatch("unexpected beat", 32'd1, 32'd0);
            else
            begin
                want = step_cmds_due.pop_front();
                if (m_tdata[0] !== want.dir)
                    flag_mismatch("step_dir", 32'(m_tdata[0]), 32'(want.dir));
                if (m_tdata[16:1] !== want.rate)
                    flag_mismatch("step_rate", 32'(m_tdata[16:1]), 32'(want.rate));
                if (m_tuser !== want.homing)
                    flag_mismatch("homing", 32'(m_tuser), 32'(want.homing));
                if (m_tdata[OUT_DATA_W-1:17] !== '0)
                    flag_mismatch("tdata padding", 32'(m_tdata[OUT_DATA_W-1:17]), 32'd0);
            end
        end
    end

    // Receiver. Mostly short ready and stall stretches, with long runs of
    // steady acceptance. Twice it refuses beats for a long stretch while the
    // sender keeps going, so every stage fills and s_tready has to drop.
    initial
    begin : result_sink
        int unsigned run;
        int          stall;
        int unsigned next_backlog;
        next_backlog = 500;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (cmds_seen >= next_backlog)
            begin
                next_backlog += 700;
                m_tready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 6);
                repeat (run) @(posedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Stimulus: reset, the directed plan, then random phases, each opening
    // with a fresh register setting written while the block is idle.
    initial
    begin : stimulus
        logic [15:0] ang;
        logic [15:0] pos;
        logic [15:0] raw;
        logic [15:0] val;
        bit          steady;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                settle();
                write_reg(plan[i].a[2:0], plan[i].b);
            end
            else
            begin
                send_tick(plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
                idle_src(pick_gap());
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            // Phase 1 has a zero rate limit, phase 2 full-scale gains and
            // limit, phases 3 and 4 the deadband extremes. Upper data bits of
            // the narrow registers are random to check that they are dropped.
            for (int r = 0; r <= int'(REG_SPARE); r++)
            begin
                raw = 16'($urandom);
                case (3'(r))
                    REG_GAIN_P, REG_GAIN_I, REG_GAIN_D:
                        val = (ph == 2) ? 16'hFFFF :
                              (ph == 7) ? raw : 16'($urandom_range(0, 1024));
                    REG_RATE_LIMIT:
                        val = (ph == 1) ? 16'h0000 :
                              (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 6000));
                    REG_DEAD_BAND:
                        val = {raw[15:8], (ph == 3) ? 8'h00 :
                                          (ph == 4) ? 8'hFF : 8'($urandom_range(0, 40))};
                    default:
                        val = raw;
                endcase
                write_reg(3'(r), val);
            end

            // The sender never idles in phase 6.
            steady = (ph == 6);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                // Halfway through phase 5 the sender waits for every result.
                if (ph == 5 && n == TICKS_PER_PHASE / 2)
                    settle();
                ang = 16'($urandom);
                // Most ticks sit near the target, where the deadband, the
                // integral and the derivative all come into play.
                if ($urandom_range(0, 9) < 7)
                    pos = 16'(angle_to_counts(ang) - (int'($urandom_range(0, 600)) - 300));
                else
                    pos = 16'($urandom);
                send_tick(ang, pos, 1'b0, '0);
                idle_src(steady ? 0 : pick_gap());
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: a correct run ends long before this.
    initial
    begin : watchdog
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
